### src/mmrc_pkg.sv
`default_nettype none
package mmrc_pkg;

	localparam int MAX_DIM = 16;
	localparam int DIM_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int CNT_W = $clog2(MAX_DIM + 1);
	localparam int ADDR_W = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
	localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;

	localparam int IDX_W = 4;
	localparam int ELEM_W = 16;
	localparam int PROD_W = 2 * ELEM_W;
	localparam int SUM_W = 36;
	localparam int SIZE_W = 5;
	localparam int GROW_W = PROD_W + $clog2(MAX_DIM) + 1;
	localparam int ACC_W = (GROW_W > SUM_W) ? GROW_W : SUM_W + 1;

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);

	typedef enum logic [1:0] {
		OP_LOAD_A  = 2'd0,
		OP_LOAD_B  = 2'd1,
		OP_COMPUTE = 2'd2
	} op_t;

	typedef enum logic {
		CFG_ROWS_M  = 1'b0,
		CFG_INNER_N = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FINISH
	} state_t;

endpackage
`default_nettype wire

### src/matrix_multiply_rowcol.sv
// Matrix product element engine. Load words (op 0 for A, op 1 for B) write one 16-bit signed
// element into the A or B store. A compute word (op 2) returns the exact sum over k of
// A[row][k]*B[k][col] for k below inner_n, as a 36-bit signed value; a row or column not
// below rows_m returns range_error with a zero sum. A compute word occupies the block while
// the single multiply-accumulate unit, which takes one product per cycle from one read port
// on each store, works through it; in_ready is low meanwhile. The result sits in an output
// register, so a load may be taken while it waits.
// Sizes above 16 act as 16. Store entries never written read back as unknown values.
`default_nettype none
module matrix_multiply_rowcol (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_we,
	input  wire                            cfg_index,
	input  wire [mmrc_pkg::SIZE_W-1:0]     cfg_data,
	input  wire                            in_valid,
	output logic                           in_ready,
	input  wire [1:0]                      op,
	input  wire [mmrc_pkg::IDX_W-1:0]      row,
	input  wire [mmrc_pkg::IDX_W-1:0]      col,
	input  wire signed [mmrc_pkg::ELEM_W-1:0] value,
	output logic                           out_valid,
	input  wire                            out_ready,
	output logic [mmrc_pkg::IDX_W-1:0]     res_row,
	output logic [mmrc_pkg::IDX_W-1:0]     res_col,
	output logic signed [mmrc_pkg::SUM_W-1:0] product_sum,
	output logic                           range_error
);
	import mmrc_pkg::*;

	localparam logic signed [ACC_W-1:0] SUM_MAX = ACC_W'({1'b0, {(SUM_W-1){1'b1}}});
	localparam logic signed [ACC_W-1:0] SUM_MIN = -SUM_MAX - ACC_W'(1);

	logic [ELEM_W-1:0] mem_a [STORE_DEPTH];
	logic [ELEM_W-1:0] mem_b [STORE_DEPTH];

	state_t state_q, state_d;
	logic [SIZE_W-1:0] rows_m_q, inner_n_q;
	logic [CNT_W-1:0] m_eff, n_eff;
	logic [CNT_W-1:0] n_q, k_q;
	logic [IDX_W-1:0] row_q, col_q;
	logic err_q;
	logic rd_v_s1, mul_v_s2;
	logic signed [ELEM_W-1:0] a_s1, b_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [SUM_W-1:0] sum_sat;
	logic accept, is_load, in_store, issue, out_load, req_err;
	logic [ADDR_W-1:0] wr_addr, addr_a, addr_b;
	logic out_valid_q;
	logic [IDX_W-1:0] res_row_q, res_col_q;
	logic signed [SUM_W-1:0] sum_q;
	logic err_out_q;

	// sizes above the store act as the store size
	assign m_eff = (rows_m_q > SIZE_W'(MAX_DIM)) ? CNT_W'(MAX_DIM) : CNT_W'(rows_m_q);
	assign n_eff = (inner_n_q > SIZE_W'(MAX_DIM)) ? CNT_W'(MAX_DIM) : CNT_W'(inner_n_q);

	assign accept = in_valid && in_ready;
	assign is_load = (op == OP_LOAD_A) || (op == OP_LOAD_B);
	assign in_store = (32'(row) < MAX_DIM) && (32'(col) < MAX_DIM);
	assign req_err = (CNT_W'(row) >= m_eff) || (CNT_W'(col) >= m_eff);
	assign wr_addr = ADDR_W'(32'(row) * MAX_DIM + 32'(col));
	assign issue = (k_q < n_q);
	assign addr_a = ADDR_W'(32'(row_q) * MAX_DIM + 32'(k_q));
	assign addr_b = ADDR_W'(32'(k_q) * MAX_DIM + 32'(col_q));

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && (op == OP_COMPUTE)) begin
					state_d = req_err ? ST_FINISH : ST_RUN;
				end
			end
			ST_RUN: begin
				// drained once nothing is left to issue and the mac pipe is empty
				if (!issue && !rd_v_s1 && !mul_v_s2) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_m_q <= SIZE_RESET;
			inner_n_q <= SIZE_RESET;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_ROWS_M:  rows_m_q <= cfg_data;
				CFG_INNER_N: inner_n_q <= cfg_data;
				default:     rows_m_q <= rows_m_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_load && in_store && (op == OP_LOAD_A)) begin
			mem_a[wr_addr] <= value;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_load && in_store && (op == OP_LOAD_B)) begin
			mem_b[wr_addr] <= value;
		end
	end

	always_ff @(posedge clk) begin
		a_s1 <= mem_a[addr_a];
		b_s1 <= mem_b[addr_b];
		prod_s2 <= a_s1 * b_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1 <= 1'b0;
			mul_v_s2 <= 1'b0;
			k_q <= '0;
			n_q <= '0;
		end else begin
			rd_v_s1 <= (state_q == ST_RUN) && issue;
			mul_v_s2 <= rd_v_s1;
			if (accept && (op == OP_COMPUTE)) begin
				k_q <= '0;
				n_q <= req_err ? '0 : n_eff;
			end else if ((state_q == ST_RUN) && issue) begin
				k_q <= k_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (op == OP_COMPUTE)) begin
			row_q <= row;
			col_q <= col;
			err_q <= req_err;
			acc_q <= '0;
		end else if (mul_v_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	// clamp only matters for stores larger than 16 by 16
	always_comb begin
		if (acc_q > SUM_MAX) begin
			sum_sat = SUM_W'(SUM_MAX);
		end else if (acc_q < SUM_MIN) begin
			sum_sat = SUM_W'(SUM_MIN);
		end else begin
			sum_sat = SUM_W'(acc_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_row_q <= row_q;
			res_col_q <= col_q;
			sum_q <= sum_sat;
			err_out_q <= err_q;
		end
	end

	assign out_valid = out_valid_q;
	assign res_row = res_row_q;
	assign res_col = res_col_q;
	assign product_sum = sum_q;
	assign range_error = err_out_q;

endmodule
`default_nettype wire
